### design/swfr_pkg.sv
// Shared types and constants for the sync-word frame receiver.
// No dependencies; the controller, the datapath and the top level import it.
package swfr_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = 16;
    localparam int IDX_W          = 4;
    localparam int BYTES_PER_WORD = 2;

    // Start-of-frame word after reset, low byte received first.
    localparam logic [WORD_W-1:0] SYNC_RESET = 16'hABCD;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic rx_take;        // a received byte is accepted this cycle
        logic rd_issue;       // read the store at the read pointer
        logic out_load_word;  // load a payload word into the output register
        logic out_load_err;   // load the checksum error result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;   // the byte on the input completes a frame
        logic frame_good;  // the checksum of that frame matches
        logic rd_last;     // the read pointer is at the last payload word
        logic out_free;    // the output register can take a result now
    } t_dp_status;

endpackage

### design/swfr_ctrl.sv
// Controller of the sync-word frame receiver: sequences byte intake,
// payload read-out and the error result. Depends on swfr_pkg.
module swfr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  swfr_pkg::t_dp_status i_status,
    output swfr_pkg::t_dp_cmd    o_cmd
);
    import swfr_pkg::*;

    typedef enum logic [1:0] {
        S_RX,    // taking bytes
        S_READ,  // reading the next payload word from the store
        S_LOAD,  // handing the word to the output register
        S_ERR    // handing the error result to the output register
    } t_state;

    t_state r_state;
    t_state n_state;

    // Bytes are taken only while collecting.
    assign o_in_stall = (r_state != S_RX);

    // Next state and datapath commands.
    always_comb begin
        n_state             = r_state;
        o_cmd               = '0;
        unique case (r_state)
            S_RX: begin
                o_cmd.rx_take = i_in_valid;
                if (i_in_valid && i_status.frame_end) begin
                    n_state = i_status.frame_good ? S_READ : S_ERR;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.out_load_word = 1'b1;
                    n_state             = i_status.rd_last ? S_RX : S_READ;
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.out_load_err = 1'b1;
                    n_state            = S_RX;
                end
            end
            default: n_state = S_RX;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/swfr_datapath.sv
// Datapath of the sync-word frame receiver: byte pairing, sync match,
// running checksum, frame store and output register. Depends on swfr_pkg.
module swfr_datapath #(
    parameter int FRAME_WORDS = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  swfr_pkg::t_dp_cmd           i_cmd,
    output swfr_pkg::t_dp_status        o_status,
    input  logic                       i_cfg_wr_en,
    input  logic [swfr_pkg::WORD_W-1:0] i_cfg_wr_data,
    input  logic [swfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_frame_ok,
    output logic [swfr_pkg::IDX_W-1:0]  o_word_index,
    output logic [swfr_pkg::WORD_W-1:0] o_word_value,
    output logic                       o_last_word
);
    import swfr_pkg::*;

    // Byte counter spans 0 .. 2*FRAME_WORDS-1; its upper bits index words.
    localparam int CW         = $clog2(BYTES_PER_WORD * FRAME_WORDS);
    localparam int WW         = CW - 1;
    localparam int STORE_DEPTH = FRAME_WORDS - 1;

    localparam logic [WW-1:0] LAST_WORD_IDX    = WW'(FRAME_WORDS - 1);
    localparam logic [WW-1:0] LAST_PAYLOAD_IDX = WW'(FRAME_WORDS - 2);

    logic [WORD_W-1:0] r_sync;
    logic [BYTE_W-1:0] r_prev_byte;
    logic [CW-1:0]     r_count;
    logic [WORD_W-1:0] r_acc;
    logic [WW-1:0]     r_rd_idx;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_out_valid;
    logic              r_frame_ok;
    logic [IDX_W-1:0]  r_word_index;
    logic [WORD_W-1:0] r_word_value;
    logic              r_last_word;

    // Payload words 1 .. FRAME_WORDS-2; entry 0 is not written, the sync word only seeds r_acc.
    logic [WORD_W-1:0] r_store [STORE_DEPTH];

    logic [WORD_W-1:0] rx_word;
    logic              sync_hit;
    logic              in_frame;
    logic              word_done;
    logic [WW-1:0]     wr_idx;
    logic              last_in;
    logic              store_wr;

    // Little-endian word from the previous and current byte.
    always_comb begin
        rx_word   = {i_rx_byte, r_prev_byte};
        sync_hit  = (rx_word == r_sync);
        in_frame  = (r_count != '0);
        word_done = in_frame && !sync_hit && r_count[0];
        wr_idx    = r_count[CW-1:1];
        last_in   = (wr_idx == LAST_WORD_IDX);
        store_wr  = i_cmd.rx_take && word_done && !last_in;
    end

    // Status toward the controller.
    always_comb begin
        o_status.frame_end  = word_done && last_in;
        o_status.frame_good = (r_acc == rx_word);
        o_status.rd_last    = (r_rd_idx == LAST_PAYLOAD_IDX);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    // Control registers: sync word, byte history, byte counter, read pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync      <= SYNC_RESET;
            r_prev_byte <= '0;
            r_count     <= '0;
            r_rd_idx    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sync <= i_cfg_wr_data;
            end
            if (i_cmd.rx_take) begin
                r_prev_byte <= i_rx_byte;
                if (sync_hit) begin
                    r_count <= CW'(BYTES_PER_WORD);
                end else if (in_frame) begin
                    if (word_done && last_in) begin
                        r_count  <= '0;
                        r_rd_idx <= WW'(1);
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            if (i_cmd.out_load_word) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    // Running XOR of all words before the checksum word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_take) begin
            if (sync_hit) begin
                r_acc <= rx_word;
            end else if (word_done && !last_in) begin
                r_acc <= r_acc ^ rx_word;
            end
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[wr_idx] <= rx_word;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_store[r_rd_idx];
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_word || i_cmd.out_load_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_word) begin
            r_frame_ok   <= 1'b1;
            r_word_index <= IDX_W'(r_rd_idx);
            r_word_value <= r_rd_data;
            r_last_word  <= (r_rd_idx == LAST_PAYLOAD_IDX);
        end else if (i_cmd.out_load_err) begin
            r_frame_ok   <= 1'b0;
            r_word_index <= '0;
            r_word_value <= '0;
            r_last_word  <= 1'b1;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_ok   = r_frame_ok;
    assign o_word_index = r_word_index;
    assign o_word_value = r_word_value;
    assign o_last_word  = r_last_word;

    // A completed frame always returns the receiver to waiting for sync.
    a_frame_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rx_take && o_status.frame_end) |=> (r_count == '0))
        else $error("byte counter not cleared after frame end");

    // The byte counter never sits on one byte or beyond the frame.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CW'(1)) && (32'(r_count) < BYTES_PER_WORD * FRAME_WORDS))
        else $error("byte counter out of range");

    // Payload read-out only touches written payload entries.
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_issue || i_cmd.out_load_word) |->
            (r_rd_idx != '0) && (r_rd_idx <= LAST_PAYLOAD_IDX))
        else $error("read pointer outside payload");

    // A result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load_word || i_cmd.out_load_err) |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten");

endmodule

### design/sync_word_frame_receiver_top.sv
// Top level of the sync-word frame receiver: joins the controller and
// the datapath. Depends on swfr_pkg, swfr_ctrl and swfr_datapath.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_rx_byte
//   out      output     o_out_valid / i_out_stall o_frame_ok, o_word_index,
//                                                 o_word_value, o_last_word
//   cfg      input      i_cfg_wr_en               i_cfg_wr_data (sync word)
//
// A byte is taken every cycle while a frame is collected or sync is sought.
// After the byte that ends a frame, the input stalls while results are issued:
// for each payload word a store read, then an output load, or else the error
// result load, and each load waits while the output is stalled.
// Reset is synchronous; it restores the sync word to 0xABCD and waits for sync.
// The output register lets a finished result wait while the next byte is taken.
module sync_word_frame_receiver_top #(
    parameter int FRAME_WORDS = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [swfr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_frame_ok,
    output logic [swfr_pkg::IDX_W-1:0]  o_word_index,
    output logic [swfr_pkg::WORD_W-1:0] o_word_value,
    output logic                       o_last_word,
    input  logic                       i_cfg_wr_en,
    input  logic [swfr_pkg::WORD_W-1:0] i_cfg_wr_data
);
    import swfr_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencing of intake and read-out.
    swfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Byte pairing, checksum, store and output register.
    swfr_datapath #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_frame_ok    (o_frame_ok),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_last_word   (o_last_word)
    );

endmodule
